// ===== rtl/stick_deadzone_smoothing_buttons_core_defines.svh =====
// assertion macros for the stick deadzone and smoothing core
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef STICK_DEADZONE_SMOOTHING_BUTTONS_CORE_DEFINES_SVH
`define STICK_DEADZONE_SMOOTHING_BUTTONS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SDSB_ASSERT_ALWAYS(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("sdsb: invariant violated");
`define SDSB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sdsb: sequence violated");
`define SDSB_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sdsb: implication violated");
`else
`define SDSB_ASSERT_ALWAYS(name, clk, rst_n, cond)
`define SDSB_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`define SDSB_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sdsb_pkg.sv =====
// shared types and constants for the stick deadzone and smoothing core
// no dependencies
package sdsb_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ONE       = 1 << FRAC_BITS;

	localparam int AXIS_W    = 16;
	localparam int DZ_W      = 14;
	localparam int ALPHA_W   = 15;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;
	localparam int OP_W      = 16;
	localparam int PROD_W    = 2 * OP_W;
	localparam int ROOT_W    = PROD_W / 2;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int ACCEL_W   = 15;
	localparam int TRICK_W   = 3;

	localparam logic [DZ_W-1:0]    DZ_RESET    = 14'd2458;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 15'd5734;

	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ALPHA = 2'd1;

	localparam logic [TRICK_W-1:0] TRICK_NONE  = 3'd0;
	localparam logic [TRICK_W-1:0] TRICK_UP    = 3'd1;
	localparam logic [TRICK_W-1:0] TRICK_DOWN  = 3'd2;
	localparam logic [TRICK_W-1:0] TRICK_LEFT  = 3'd3;
	localparam logic [TRICK_W-1:0] TRICK_RIGHT = 3'd4;

	typedef struct packed {
		logic signed [AXIS_W-1:0] stick_x;
		logic signed [AXIS_W-1:0] stick_y;
		logic button_a;
		logic button_b;
		logic button_r;
		logic button_l;
		logic pad_up;
		logic pad_down;
		logic pad_left;
		logic pad_right;
	} poll_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] steer_out;
		logic [ACCEL_W-1:0]       accel_out;
		logic signed [AXIS_W-1:0] filtered_x;
		logic signed [AXIS_W-1:0] filtered_y;
		logic brake_on;
		logic drift_on;
		logic item_pulse;
		logic [TRICK_W-1:0] trick_dir;
		logic trigger_left;
		logic trigger_right;
	} ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_GO,
		ST_SQ_RUN,
		ST_RT_GO,
		ST_RT_RUN,
		ST_PR_GO,
		ST_PR_RUN,
		ST_DV_GO,
		ST_DV_RUN,
		ST_FILTER,
		ST_SM_GO,
		ST_SM_RUN,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/sdsb_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on sdsb_pkg
module sdsb_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sdsb_pkg::OP_W-1:0]     a,
	input  logic [sdsb_pkg::OP_W-1:0]     b,
	output logic [sdsb_pkg::PROD_W-1:0]   p,
	output sdsb_pkg::unit_sts_t           sts
);
	localparam int STEPS = sdsb_pkg::OP_W;
	localparam int CW    = $clog2(STEPS);
	localparam int OW    = sdsb_pkg::OP_W;
	localparam int PW    = sdsb_pkg::PROD_W;

	logic [OW-1:0] a_q;
	logic [PW-1:0] p_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [OW:0]   psum;

	assign psum = {1'b0, p_q[PW-1:OW]} + (p_q[0] ? {1'b0, a_q} : {(OW+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{(PW-OW){1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {psum, p_q[OW-1:1]};
		end
	end

	assign p        = p_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

// ===== rtl/sdsb_isqrt.sv =====
// digit-serial integer square root, two radicand bits per cycle
// depends on sdsb_pkg
module sdsb_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sdsb_pkg::PROD_W-1:0]   v,
	output logic [sdsb_pkg::ROOT_W-1:0]   root,
	output sdsb_pkg::unit_sts_t           sts
);
	localparam int RW    = sdsb_pkg::ROOT_W;
	localparam int VW    = sdsb_pkg::PROD_W;
	localparam int STEPS = RW;
	localparam int CW    = $clog2(STEPS);

	logic [VW-1:0] v_q;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [RW+3:0] cur;
	logic [RW+3:0] trial;
	logic [RW+3:0] diffv;
	logic          ge;

	assign cur   = {rem_q, v_q[VW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = (cur >= trial);
	assign diffv = cur - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= v;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[VW-3:0], 2'b00};
			rem_q  <= ge ? diffv[RW+1:0] : cur[RW+1:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign root     = root_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

// ===== rtl/sdsb_div.sv =====
// restoring divider giving floor(n * ONE / d) one quotient bit per cycle
// saturates to ONE; depends on sdsb_pkg
module sdsb_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sdsb_pkg::PROD_W-1:0]   n,
	input  logic [sdsb_pkg::PROD_W-1:0]   d,
	output logic [sdsb_pkg::QUO_W-1:0]    q,
	output sdsb_pkg::unit_sts_t           sts
);
	localparam int PW    = sdsb_pkg::PROD_W;
	localparam int QW    = sdsb_pkg::QUO_W;
	localparam int STEPS = QW;
	localparam int CW    = $clog2(STEPS);
	localparam logic [QW-1:0] Q_ONE = QW'(sdsb_pkg::ONE);

	logic [PW-1:0] r_q;
	logic [PW-1:0] d_q;
	logic [QW-1:0] q_q;
	logic          ovf_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          ge;
	logic [PW-1:0] rs;

	assign ge = (r_q >= d_q);
	assign rs = ge ? (r_q - d_q) : r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient of two or more before scaling cannot fit
	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= n;
			d_q   <= d;
			q_q   <= '0;
			ovf_q <= ({1'b0, n} >= {d, 1'b0});
		end else if (busy_q) begin
			r_q <= {rs[PW-2:0], 1'b0};
			q_q <= {q_q[QW-2:0], ge};
		end
	end

	assign q        = (ovf_q || (q_q > Q_ONE)) ? Q_ONE : q_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

// ===== rtl/stick_deadzone_smoothing_buttons_core.sv =====
// Stick deadzone, rescale, steering smoothing and button decode.
// Takes one poll request, sequences five bit-serial passes through shared
// shift-add multipliers, a square-root unit and two dividers, and returns
// one result. A new request is accepted only in the idle state, after the
// result of the previous one has been loaded. The five passes run 15 or 16
// steps each (squares, root, scale products, division, smoothing product).
// The result sits in an output register, so a stalled result does not hold
// the computation of the following request. Configuration writes are taken
// at any edge and should be made while the block is idle.
// depends on sdsb_pkg, sdsb_mul, sdsb_isqrt, sdsb_div
`include "stick_deadzone_smoothing_buttons_core_defines.svh"
module stick_deadzone_smoothing_buttons_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            poll_valid,
	output logic                            poll_stall,
	input  sdsb_pkg::poll_t                 poll_data,
	output logic                            ctl_valid,
	input  logic                            ctl_stall,
	output sdsb_pkg::ctl_t                  ctl_data,
	input  logic                            cfg_wr_en,
	input  logic [sdsb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sdsb_pkg::CFG_W-1:0]      cfg_data
);
	localparam int AW     = sdsb_pkg::AXIS_W;
	localparam int OW     = sdsb_pkg::OP_W;
	localparam int PW     = sdsb_pkg::PROD_W;
	localparam int RW     = sdsb_pkg::ROOT_W;
	localparam int QW     = sdsb_pkg::QUO_W;
	localparam int DW     = sdsb_pkg::DZ_W;
	localparam int FB     = sdsb_pkg::FRAC_BITS;
	localparam int STEP_W = PW + 1 - FB;
	localparam int SUM_W  = STEP_W + 2;
	localparam logic signed [AW-1:0]    AX_ONE   = AW'(sdsb_pkg::ONE);
	localparam logic signed [AW-1:0]    AX_MONE  = -AX_ONE;
	localparam logic signed [SUM_W-1:0] SUM_ONE  = SUM_W'(sdsb_pkg::ONE);
	localparam logic signed [SUM_W-1:0] SUM_MONE = -SUM_ONE;
	localparam logic [PW:0]             HALF     = (PW+1)'(1 << (FB - 1));
	localparam logic [QW-1:0]           Q_ONE    = QW'(sdsb_pkg::ONE);

	sdsb_pkg::state_t state_q, state_d;

	logic [DW-1:0]                   dz_q;
	logic [sdsb_pkg::ALPHA_W-1:0]    alpha_q;
	logic signed [AW-1:0]            last_steer_q;
	logic                            last_a_q;
	logic                            res_valid_q;
	sdsb_pkg::ctl_t                  res_q;

	logic [AW-1:0]                   x_q, y_q;
	logic                            bb_q, br_q, bl_q, pulse_q;
	logic [sdsb_pkg::TRICK_W-1:0]    trick_q, trick_d;
	logic signed [AW-1:0]            fx_q, fy_q;
	logic                            diff_neg_q;

	logic accept, out_free, res_load;
	logic mul_a_start, mul_b_start, mul_c_start, sqrt_start, div_start;
	logic [OW-1:0] mul_a_a, mul_a_b, mul_b_a, mul_b_b, mul_c_a, mul_c_b;
	logic [PW-1:0] prod_a, prod_b, prod_c;
	logic [RW-1:0] root;
	logic [QW-1:0] q_x, q_y;
	sdsb_pkg::unit_sts_t sts_a, sts_b, sts_c, sts_r, sts_dx, sts_dy;

	logic [AW-1:0]        ax, ay;
	logic                 mag_gt;
	logic [RW-1:0]        span;
	logic [QW-1:0]        one_minus_dz;
	logic [AW-1:0]        fx_d, fy_d;
	logic [AW:0]          diff, adiff;
	logic [PW:0]          rnd;
	logic [STEP_W-1:0]    step_mag;
	logic signed [SUM_W-1:0] last_ext, step_ext, steer_sum;
	logic signed [AW-1:0] steer_sat;
	logic [AW-1:0]        fy_neg;
	logic [sdsb_pkg::ACCEL_W-1:0] accel;

	function automatic logic [AW-1:0] signed_axis(input logic [QW-1:0] mag, input logic neg);
		logic [AW-1:0] m;
		m = {{(AW-QW){1'b0}}, mag};
		return neg ? (~m + AW'(1)) : m;
	endfunction

	assign accept     = poll_valid && (state_q == sdsb_pkg::ST_IDLE);
	assign poll_stall = (state_q != sdsb_pkg::ST_IDLE);
	assign out_free   = !res_valid_q || !ctl_stall;

	// operand preparation
	assign ax           = x_q[AW-1] ? (~x_q + AW'(1)) : x_q;
	assign ay           = y_q[AW-1] ? (~y_q + AW'(1)) : y_q;
	assign mag_gt       = root > {{(RW-DW){1'b0}}, dz_q};
	assign span         = mag_gt ? (root - {{(RW-DW){1'b0}}, dz_q}) : '0;
	assign one_minus_dz = Q_ONE - {{(QW-DW){1'b0}}, dz_q};
	assign fx_d         = mag_gt ? signed_axis(q_x, x_q[AW-1]) : '0;
	assign fy_d         = mag_gt ? signed_axis(q_y, y_q[AW-1]) : '0;
	assign diff         = {fx_q[AW-1], fx_q} - {last_steer_q[AW-1], last_steer_q};
	assign adiff        = diff[AW] ? (~diff + (AW+1)'(1)) : diff;

	// smoothing step, rounded half away from zero, then saturated
	assign rnd       = {1'b0, prod_a} + HALF;
	assign step_mag  = rnd[PW:FB];
	assign last_ext  = SUM_W'(last_steer_q);
	assign step_ext  = {2'b00, step_mag};
	assign steer_sum = diff_neg_q ? (last_ext - step_ext) : (last_ext + step_ext);
	always_comb begin
		if (steer_sum > SUM_ONE) begin
			steer_sat = AX_ONE;
		end else if (steer_sum < SUM_MONE) begin
			steer_sat = AX_MONE;
		end else begin
			steer_sat = steer_sum[AW-1:0];
		end
	end

	assign fy_neg = ~fy_q + AW'(1);
	assign accel  = fy_q[AW-1] ? fy_neg[sdsb_pkg::ACCEL_W-1:0] : '0;

	always_comb begin
		if (poll_data.pad_up) begin
			trick_d = sdsb_pkg::TRICK_UP;
		end else if (poll_data.pad_down) begin
			trick_d = sdsb_pkg::TRICK_DOWN;
		end else if (poll_data.pad_left) begin
			trick_d = sdsb_pkg::TRICK_LEFT;
		end else if (poll_data.pad_right) begin
			trick_d = sdsb_pkg::TRICK_RIGHT;
		end else begin
			trick_d = sdsb_pkg::TRICK_NONE;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdsb_pkg::ST_IDLE:   if (poll_valid) state_d = sdsb_pkg::ST_SQ_GO;
			sdsb_pkg::ST_SQ_GO:  state_d = sdsb_pkg::ST_SQ_RUN;
			sdsb_pkg::ST_SQ_RUN: if (sts_a.done) state_d = sdsb_pkg::ST_RT_GO;
			sdsb_pkg::ST_RT_GO:  state_d = sdsb_pkg::ST_RT_RUN;
			sdsb_pkg::ST_RT_RUN: if (sts_r.done) state_d = sdsb_pkg::ST_PR_GO;
			sdsb_pkg::ST_PR_GO:  state_d = sdsb_pkg::ST_PR_RUN;
			sdsb_pkg::ST_PR_RUN: if (sts_a.done) state_d = sdsb_pkg::ST_DV_GO;
			sdsb_pkg::ST_DV_GO:  state_d = sdsb_pkg::ST_DV_RUN;
			sdsb_pkg::ST_DV_RUN: if (sts_dx.done) state_d = sdsb_pkg::ST_FILTER;
			sdsb_pkg::ST_FILTER: state_d = sdsb_pkg::ST_SM_GO;
			sdsb_pkg::ST_SM_GO:  state_d = sdsb_pkg::ST_SM_RUN;
			sdsb_pkg::ST_SM_RUN: if (sts_a.done) state_d = sdsb_pkg::ST_FINISH;
			sdsb_pkg::ST_FINISH: if (out_free) state_d = sdsb_pkg::ST_IDLE;
			default:             state_d = sdsb_pkg::ST_IDLE;
		endcase
	end

	// unit starts and operand select
	always_comb begin
		mul_a_start = 1'b0;
		mul_b_start = 1'b0;
		mul_c_start = 1'b0;
		sqrt_start  = 1'b0;
		div_start   = 1'b0;
		res_load    = 1'b0;
		mul_a_a     = '0;
		mul_a_b     = '0;
		mul_b_a     = '0;
		mul_b_b     = '0;
		mul_c_a     = '0;
		mul_c_b     = '0;
		unique case (state_q)
			sdsb_pkg::ST_SQ_GO: begin
				mul_a_start = 1'b1;
				mul_b_start = 1'b1;
				mul_a_a     = ax;
				mul_a_b     = ax;
				mul_b_a     = ay;
				mul_b_b     = ay;
			end
			sdsb_pkg::ST_RT_GO: begin
				sqrt_start = 1'b1;
			end
			sdsb_pkg::ST_PR_GO: begin
				mul_a_start = 1'b1;
				mul_b_start = 1'b1;
				mul_c_start = 1'b1;
				mul_a_a     = ax;
				mul_a_b     = span;
				mul_b_a     = ay;
				mul_b_b     = span;
				mul_c_a     = {{(OW-QW){1'b0}}, one_minus_dz};
				mul_c_b     = root;
			end
			sdsb_pkg::ST_DV_GO: begin
				div_start = 1'b1;
			end
			sdsb_pkg::ST_SM_GO: begin
				mul_a_start = 1'b1;
				mul_a_a     = {{(OW-sdsb_pkg::ALPHA_W){1'b0}}, alpha_q};
				mul_a_b     = adiff[OW-1:0];
			end
			sdsb_pkg::ST_FINISH: begin
				res_load = out_free;
			end
			default: begin
			end
		endcase
	end

	sdsb_mul u_mul_a (
		.clk(clk), .arst_n(arst_n), .start(mul_a_start),
		.a(mul_a_a), .b(mul_a_b), .p(prod_a), .sts(sts_a)
	);

	sdsb_mul u_mul_b (
		.clk(clk), .arst_n(arst_n), .start(mul_b_start),
		.a(mul_b_a), .b(mul_b_b), .p(prod_b), .sts(sts_b)
	);

	sdsb_mul u_mul_c (
		.clk(clk), .arst_n(arst_n), .start(mul_c_start),
		.a(mul_c_a), .b(mul_c_b), .p(prod_c), .sts(sts_c)
	);

	sdsb_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.v(prod_a + prod_b), .root(root), .sts(sts_r)
	);

	sdsb_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.n(prod_a), .d(prod_c), .q(q_x), .sts(sts_dx)
	);

	sdsb_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.n(prod_b), .d(prod_c), .q(q_y), .sts(sts_dy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sdsb_pkg::ST_IDLE;
			dz_q         <= sdsb_pkg::DZ_RESET;
			alpha_q      <= sdsb_pkg::ALPHA_RESET;
			last_steer_q <= '0;
			last_a_q     <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					sdsb_pkg::REG_DEAD_ZONE:    dz_q    <= cfg_data[DW-1:0];
					sdsb_pkg::REG_SMOOTH_ALPHA: alpha_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				last_a_q <= poll_data.button_a;
			end
			if (res_load) begin
				last_steer_q <= steer_sat;
				res_valid_q  <= 1'b1;
			end else if (ctl_valid && !ctl_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= poll_data.stick_x;
			y_q     <= poll_data.stick_y;
			bb_q    <= poll_data.button_b;
			br_q    <= poll_data.button_r;
			bl_q    <= poll_data.button_l;
			pulse_q <= poll_data.button_a && !last_a_q;
			trick_q <= trick_d;
		end
		if (state_q == sdsb_pkg::ST_FILTER) begin
			fx_q <= fx_d;
			fy_q <= fy_d;
		end
		if (state_q == sdsb_pkg::ST_SM_GO) begin
			diff_neg_q <= diff[AW];
		end
		if (res_load) begin
			res_q.steer_out     <= steer_sat;
			res_q.accel_out     <= accel;
			res_q.filtered_x    <= fx_q;
			res_q.filtered_y    <= fy_q;
			res_q.brake_on      <= bb_q;
			res_q.drift_on      <= br_q;
			res_q.item_pulse    <= pulse_q;
			res_q.trick_dir     <= trick_q;
			res_q.trigger_left  <= bl_q;
			res_q.trigger_right <= br_q;
		end
	end

	assign ctl_valid = res_valid_q;
	assign ctl_data  = res_q;

	`SDSB_ASSERT_NEXT(a_accept_starts, clk, arst_n, poll_valid && !poll_stall, state_q == sdsb_pkg::ST_SQ_GO)
	`SDSB_ASSERT_ALWAYS(a_mul_lockstep, clk, arst_n, sts_a.done == sts_b.done || state_q == sdsb_pkg::ST_SM_RUN || state_q == sdsb_pkg::ST_FINISH)
	`SDSB_ASSERT_ALWAYS(a_div_start_idle, clk, arst_n, !(div_start && (sts_dx.busy || sts_dy.busy)))
	`SDSB_ASSERT_IMPLY(a_result_range, clk, arst_n, ctl_valid, ctl_data.steer_out <= AX_ONE && ctl_data.steer_out >= AX_MONE && (ctl_data.accel_out == '0 || ctl_data.filtered_y < 0))
endmodule
